>>> design/pmcab_pkg.sv
// ----------------------------------------------------------------------------
// pmcab_pkg
// Shared types, register map and arithmetic helpers for the pixel mode
// converter and alpha blender.
// ----------------------------------------------------------------------------
package pmcab_pkg;

	localparam int unsigned CHAN_W = 8;
	localparam int unsigned PROD_W = 2 * CHAN_W;
	localparam logic [CHAN_W-1:0] FULL = 8'hFF;

	// register map, selected by paddr[2]
	localparam logic REG_COLOR_MODE = 1'b0;
	localparam logic REG_CHANNEL_COUNT = 1'b1;

	localparam logic [2:0] COLOR_MODE_RST = 3'd1;
	localparam logic [2:0] CHANNEL_COUNT_RST = 3'd4;
	localparam logic [2:0] CHAN_GRAY_MIN = 3'd1;
	localparam logic [2:0] CHAN_RGB_MIN = 3'd3;
	localparam logic [2:0] CHAN_FULL_MIN = 3'd4;

	typedef enum logic [1:0] {
		MODE_GRAY,
		MODE_RGB,
		MODE_CMYK,
		MODE_NONE
	} color_mode_t;

	typedef enum logic [1:0] {
		SEL_BACK,
		SEL_TOP,
		SEL_MIX
	} blend_sel_t;

	typedef struct packed {
		logic [CHAN_W-1:0] a;
		logic [CHAN_W-1:0] b;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] r;
	} pixel_t;

	typedef struct packed {
		logic [CHAN_W-1:0] s3;
		logic [CHAN_W-1:0] s2;
		logic [CHAN_W-1:0] s1;
		logic [CHAN_W-1:0] s0;
	} samples_t;

	typedef struct packed {
		pixel_t back;
		logic   in_image;
	} side_t;

	typedef struct packed {
		pixel_t top;
		side_t  side;
	} conv_out_t;

	// floor(x / 255), exact for x up to 255*255
	function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W:0] t;
		t = {1'b0, x} + {{(CHAN_W+1){1'b0}}, x[PROD_W-1:CHAN_W]} + {{PROD_W{1'b0}}, 1'b1};
		return t[PROD_W-1:CHAN_W];
	endfunction

endpackage

>>> design/pmcab_convert.sv
// ----------------------------------------------------------------------------
// pmcab_convert
// Two-stage color mode conversion of the channel samples to an RGBA top pixel;
// background and in-image flag ride along.
// ----------------------------------------------------------------------------
module pmcab_convert (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  pmcab_pkg::samples_t        in_samples,
	input  pmcab_pkg::side_t           in_side,
	input  pmcab_pkg::color_mode_t     color_mode,
	input  logic [2:0]                 channel_count,
	output logic                       out_valid,
	input  logic                       out_ready,
	output pmcab_pkg::conv_out_t       out_data
);

	logic                              v_s1;
	logic                              v_s2;
	logic                              rdy_s1;
	logic                              rdy_s2;

	logic                              cmyk_s1;
	logic [pmcab_pkg::PROD_W-1:0]      r_s1;
	logic [pmcab_pkg::PROD_W-1:0]      g_s1;
	logic [pmcab_pkg::PROD_W-1:0]      b_s1;
	logic [pmcab_pkg::CHAN_W-1:0]      a_s1;
	pmcab_pkg::side_t                  side_s1;

	pmcab_pkg::conv_out_t              data_s2;

	logic                              cmyk_c;
	logic [pmcab_pkg::PROD_W-1:0]      r_c;
	logic [pmcab_pkg::PROD_W-1:0]      g_c;
	logic [pmcab_pkg::PROD_W-1:0]      b_c;
	logic [pmcab_pkg::CHAN_W-1:0]      a_c;
	logic [pmcab_pkg::CHAN_W-1:0]      inv_k;

	assign rdy_s2 = !v_s2 || out_ready;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_comb begin
		inv_k = pmcab_pkg::FULL - in_samples.s3;
		cmyk_c = 1'b0;
		r_c = '0;
		g_c = '0;
		b_c = '0;
		a_c = pmcab_pkg::FULL;
		case (color_mode)
			pmcab_pkg::MODE_GRAY: begin
				if (channel_count >= pmcab_pkg::CHAN_GRAY_MIN) begin
					r_c = {{pmcab_pkg::CHAN_W{1'b0}}, in_samples.s0};
					g_c = {{pmcab_pkg::CHAN_W{1'b0}}, in_samples.s0};
					b_c = {{pmcab_pkg::CHAN_W{1'b0}}, in_samples.s0};
				end
			end
			pmcab_pkg::MODE_RGB: begin
				if (channel_count >= pmcab_pkg::CHAN_RGB_MIN) begin
					r_c = {{pmcab_pkg::CHAN_W{1'b0}}, in_samples.s0};
					g_c = {{pmcab_pkg::CHAN_W{1'b0}}, in_samples.s1};
					b_c = {{pmcab_pkg::CHAN_W{1'b0}}, in_samples.s2};
					if (channel_count >= pmcab_pkg::CHAN_FULL_MIN) begin
						a_c = in_samples.s3;
					end
				end
			end
			pmcab_pkg::MODE_CMYK: begin
				if (channel_count >= pmcab_pkg::CHAN_FULL_MIN) begin
					cmyk_c = 1'b1;
					r_c = (pmcab_pkg::FULL - in_samples.s0) * inv_k;
					g_c = (pmcab_pkg::FULL - in_samples.s1) * inv_k;
					b_c = (pmcab_pkg::FULL - in_samples.s2) * inv_k;
				end
			end
			default: begin
				// unsupported mode keeps opaque black
				cmyk_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			cmyk_s1 <= cmyk_c;
			r_s1 <= r_c;
			g_s1 <= g_c;
			b_s1 <= b_c;
			a_s1 <= a_c;
			side_s1 <= in_side;
		end
		if (rdy_s2 && v_s1) begin
			data_s2.top.r <= cmyk_s1 ? pmcab_pkg::div255(r_s1) : r_s1[pmcab_pkg::CHAN_W-1:0];
			data_s2.top.g <= cmyk_s1 ? pmcab_pkg::div255(g_s1) : g_s1[pmcab_pkg::CHAN_W-1:0];
			data_s2.top.b <= cmyk_s1 ? pmcab_pkg::div255(b_s1) : b_s1[pmcab_pkg::CHAN_W-1:0];
			data_s2.top.a <= a_s1;
			data_s2.side <= side_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_data = data_s2;

endmodule

>>> design/pixel_mode_convert_and_alpha_blend.sv
// ----------------------------------------------------------------------------
// pixel_mode_convert_and_alpha_blend
// Converts gray, RGB or CMYK samples to RGBA and blends them over a background.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output side does not stall, and holds
// no state between pixels. A pixel spends four register stages in the block:
// mode decode and CMYK product, divide by 255, blend products, and divide by
// 255 into the output register. Every stage has its own valid bit and moves
// whenever the stage after it is empty or moving, so bubbles are squeezed out
// under backpressure.
// Registers: color_mode at 0x0, channel_count at 0x4; write them only while
// the block is empty.
module pixel_mode_convert_and_alpha_blend (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// sample_first, sample_second, sample_third, sample_fourth,
	// back_red, back_green, back_blue, back_alpha
	input  logic [63:0] s_tdata,
	// inside_image
	input  logic [0:0]  s_tuser,
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_red, out_green, out_blue, out_alpha
	output logic [31:0] m_tdata,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	pmcab_pkg::color_mode_t           color_mode_q;
	logic [2:0]                       channel_count_q;
	logic                             cfg_wr;

	pmcab_pkg::samples_t              in_samples;
	pmcab_pkg::side_t                 in_side;

	logic                             conv_valid;
	logic                             conv_ready;
	pmcab_pkg::conv_out_t             conv_data;

	logic                             v_s3;
	logic                             v_s4;
	logic                             rdy_s3;
	logic                             rdy_s4;

	pmcab_pkg::blend_sel_t            sel_s3;
	pmcab_pkg::pixel_t                top_s3;
	pmcab_pkg::pixel_t                back_s3;
	logic [pmcab_pkg::PROD_W-1:0]     sum_r_s3;
	logic [pmcab_pkg::PROD_W-1:0]     sum_g_s3;
	logic [pmcab_pkg::PROD_W-1:0]     sum_b_s3;
	logic [pmcab_pkg::CHAN_W-1:0]     max_a_s3;

	pmcab_pkg::pixel_t                out_s4;

	pmcab_pkg::blend_sel_t            sel_c;
	logic [pmcab_pkg::CHAN_W-1:0]     inv_a;
	pmcab_pkg::pixel_t                top_c;
	pmcab_pkg::pixel_t                back_c;
	pmcab_pkg::pixel_t                out_c;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= pmcab_pkg::color_mode_t'(pmcab_pkg::COLOR_MODE_RST[1:0]);
			channel_count_q <= pmcab_pkg::CHANNEL_COUNT_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == pmcab_pkg::REG_COLOR_MODE) begin
				color_mode_q <= pmcab_pkg::color_mode_t'(pwdata[1:0]);
			end else begin
				channel_count_q <= pwdata[2:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == pmcab_pkg::REG_CHANNEL_COUNT) begin
			prdata = {29'd0, channel_count_q};
		end else begin
			prdata = {30'd0, color_mode_q};
		end
	end

	// stream unpacking
	assign in_samples.s0 = s_tdata[7:0];
	assign in_samples.s1 = s_tdata[15:8];
	assign in_samples.s2 = s_tdata[23:16];
	assign in_samples.s3 = s_tdata[31:24];
	assign in_side.back.r = s_tdata[39:32];
	assign in_side.back.g = s_tdata[47:40];
	assign in_side.back.b = s_tdata[55:48];
	assign in_side.back.a = s_tdata[63:56];
	assign in_side.in_image = s_tuser[0];

	pmcab_convert u_convert (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_samples    (in_samples),
		.in_side       (in_side),
		.color_mode    (color_mode_q),
		.channel_count (channel_count_q),
		.out_valid     (conv_valid),
		.out_ready     (conv_ready),
		.out_data      (conv_data)
	);

	assign rdy_s4 = !v_s4 || m_tready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign conv_ready = rdy_s3;

	// blend products and path select
	always_comb begin
		top_c = conv_data.top;
		back_c = conv_data.side.back;
		inv_a = pmcab_pkg::FULL - top_c.a;
		if (!conv_data.side.in_image || top_c.a == '0) begin
			sel_c = pmcab_pkg::SEL_BACK;
		end else if (top_c.a == pmcab_pkg::FULL) begin
			sel_c = pmcab_pkg::SEL_TOP;
		end else begin
			sel_c = pmcab_pkg::SEL_MIX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s3) begin
				v_s3 <= conv_valid;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && conv_valid) begin
			sel_s3 <= sel_c;
			top_s3 <= top_c;
			back_s3 <= back_c;
			sum_r_s3 <= top_c.r * top_c.a + back_c.r * inv_a;
			sum_g_s3 <= top_c.g * top_c.a + back_c.g * inv_a;
			sum_b_s3 <= top_c.b * top_c.a + back_c.b * inv_a;
			max_a_s3 <= (top_c.a > back_c.a) ? top_c.a : back_c.a;
		end
		if (rdy_s4 && v_s3) begin
			out_s4 <= out_c;
		end
	end

	// final divide and select
	always_comb begin
		case (sel_s3)
			pmcab_pkg::SEL_TOP: begin
				out_c = top_s3;
			end
			pmcab_pkg::SEL_MIX: begin
				out_c.r = pmcab_pkg::div255(sum_r_s3);
				out_c.g = pmcab_pkg::div255(sum_g_s3);
				out_c.b = pmcab_pkg::div255(sum_b_s3);
				out_c.a = max_a_s3;
			end
			default: begin
				out_c = back_s3;
			end
		endcase
	end

	assign m_tvalid = v_s4;
	assign m_tdata = {out_s4.a, out_s4.b, out_s4.g, out_s4.r};

	// a blend-stage item that can move must land in the output register
	a_s3_moves: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && rdy_s4 |=> m_tvalid)
		else $error("blend stage item lost");

	// output drains when taken and nothing follows
	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !v_s3 |=> !m_tvalid)
		else $error("result repeated");

	// a waiting result must hold its value
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// an opaque blend result always carries full alpha
	a_top_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && rdy_s4 && sel_s3 == pmcab_pkg::SEL_TOP |=> m_tdata[31:24] == pmcab_pkg::FULL)
		else $error("opaque result lost alpha");

endmodule

>>> tb/pixel_mode_convert_and_alpha_blend_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_mode_convert_and_alpha_blend_checker
// Watches the request and result streams and the register port, works out
// the blended pixel for every accepted request and compares each result
// field by field, in order, against the oldest expected pixel.
// ----------------------------------------------------------------------------
module pixel_mode_convert_and_alpha_blend_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// sample_first, sample_second, sample_third, sample_fourth,
	// back_red, back_green, back_blue, back_alpha
	input  logic [63:0] s_tdata,
	// inside_image
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// out_red, out_green, out_blue, out_alpha
	input  logic [31:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          pending
);

	localparam int OPAQUE = 255;

	pmcab_pkg::color_mode_t mode_now = pmcab_pkg::MODE_RGB;
	int                     count_now = 4;
	pmcab_pkg::pixel_t      expected_pixels[$];
	pmcab_pkg::pixel_t      got_pixel;
	pmcab_pkg::pixel_t      want_pixel;
	int                     fail_tally = 0;

	function automatic logic [7:0] mix_channel(input int top_val, input int back_val,
			input int alpha);
		return 8'((top_val * alpha + back_val * (OPAQUE - alpha)) / OPAQUE);
	endfunction

	function automatic logic [7:0] ink_to_rgb(input int ink, input int black);
		return 8'(((OPAQUE - ink) * (OPAQUE - black)) / OPAQUE);
	endfunction

	function automatic pmcab_pkg::pixel_t predict_pixel(input pmcab_pkg::color_mode_t mode,
			input int count, input pmcab_pkg::samples_t smp,
			input pmcab_pkg::pixel_t back, input logic in_image);
		pmcab_pkg::pixel_t top;
		pmcab_pkg::pixel_t res;
		int                chans;
		chans = (count > 4) ? 4 : count;
		// opaque black unless the mode has enough channels
		top = '0;
		top.a = 8'hFF;
		case (mode)
			pmcab_pkg::MODE_GRAY: begin
				if (chans >= 1) begin
					top.r = smp.s0;
					top.g = smp.s0;
					top.b = smp.s0;
				end
			end
			pmcab_pkg::MODE_RGB: begin
				if (chans >= 3) begin
					top.r = smp.s0;
					top.g = smp.s1;
					top.b = smp.s2;
					if (chans == 4) begin
						top.a = smp.s3;
					end
				end
			end
			pmcab_pkg::MODE_CMYK: begin
				if (chans == 4) begin
					top.r = ink_to_rgb(smp.s0, smp.s3);
					top.g = ink_to_rgb(smp.s1, smp.s3);
					top.b = ink_to_rgb(smp.s2, smp.s3);
				end
			end
			default: begin
			end
		endcase
		if (!in_image || top.a == 8'h00) begin
			res = back;
		end else if (top.a == 8'hFF) begin
			res = top;
		end else begin
			res.r = mix_channel(top.r, back.r, top.a);
			res.g = mix_channel(top.g, back.g, top.a);
			res.b = mix_channel(top.b, back.b, top.a);
			res.a = (top.a > back.a) ? top.a : back.a;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int seen, input int want);
		$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, seen, want);
		fail_tally++;
	endtask

	task automatic check_field(input string what, input logic [7:0] seen,
			input logic [7:0] want);
		if (seen !== want) begin
			report_mismatch(what, seen, want);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_now = pmcab_pkg::color_mode_t'(pmcab_pkg::COLOR_MODE_RST[1:0]);
			count_now = int'(pmcab_pkg::CHANNEL_COUNT_RST);
			expected_pixels.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == pmcab_pkg::REG_CHANNEL_COUNT) begin
					count_now = int'(pwdata[2:0]);
				end else begin
					mode_now = pmcab_pkg::color_mode_t'(pwdata[1:0]);
				end
			end
			// results always leave after their request is accepted, so pop first
			if (m_tvalid && m_tready) begin
				got_pixel = pmcab_pkg::pixel_t'(m_tdata);
				if (expected_pixels.size() == 0) begin
					report_mismatch("pixel with no request pending", m_tdata, 0);
				end else begin
					want_pixel = expected_pixels.pop_front();
					check_field("out_red", got_pixel.r, want_pixel.r);
					check_field("out_green", got_pixel.g, want_pixel.g);
					check_field("out_blue", got_pixel.b, want_pixel.b);
					check_field("out_alpha", got_pixel.a, want_pixel.a);
				end
			end
			if (s_tvalid && s_tready) begin
				expected_pixels.push_back(predict_pixel(mode_now, count_now,
					pmcab_pkg::samples_t'(s_tdata[31:0]),
					pmcab_pkg::pixel_t'(s_tdata[63:32]), s_tuser[0]));
			end
			mismatches <= fail_tally;
			pending <= expected_pixels.size();
		end
	end

endmodule

>>> tb/pixel_mode_convert_and_alpha_blend_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_mode_convert_and_alpha_blend_test
// Drives pixels through the converter and blender under a series of color
// mode and channel count settings, first a few hand-picked pixels per
// setting, then random pixels, with random gaps on the request side and
// random backpressure on the result side. The checker does the comparing.
// ----------------------------------------------------------------------------
module pixel_mode_convert_and_alpha_blend_test;

	localparam logic [2:0] ADDR_COLOR_MODE = {pmcab_pkg::REG_COLOR_MODE, 2'b00};
	localparam logic [2:0] ADDR_CHANNEL_COUNT = {pmcab_pkg::REG_CHANNEL_COUNT, 2'b00};
	localparam int IDLE_PERCENT = 11;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_PIXELS = 104;
	localparam int QUIET_PHASE = 4;
	localparam int DRAIN_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// sample_first, sample_second, sample_third, sample_fourth,
	// back_red, back_green, back_blue, back_alpha
	logic [63:0] s_tdata = '0;
	// inside_image
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	// out_red, out_green, out_blue, out_alpha
	logic [31:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        quiet = 1'b0;
	int          fail_count;
	int          pixels_in_flight;

	pmcab_pkg::color_mode_t dir_mode [8] = '{pmcab_pkg::MODE_RGB, pmcab_pkg::MODE_RGB,
		pmcab_pkg::MODE_GRAY, pmcab_pkg::MODE_CMYK, pmcab_pkg::MODE_NONE,
		pmcab_pkg::MODE_GRAY, pmcab_pkg::MODE_CMYK, pmcab_pkg::MODE_RGB};
	int                     dir_count [8] = '{4, 3, 1, 4, 4, 0, 3, 7};
	pmcab_pkg::color_mode_t fixed_mode [6] = '{pmcab_pkg::MODE_GRAY, pmcab_pkg::MODE_NONE,
		pmcab_pkg::MODE_CMYK, pmcab_pkg::MODE_RGB, pmcab_pkg::MODE_RGB,
		pmcab_pkg::MODE_CMYK};
	int                     fixed_count [6] = '{0, 7, 4, 3, 4, 5};

	pixel_mode_convert_and_alpha_blend u_top (.*);

	pixel_mode_convert_and_alpha_blend_checker u_checker (
		.mismatches(fail_count),
		.pending(pixels_in_flight),
		.*
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
	end

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_config(input pmcab_pkg::color_mode_t mode, input int count);
		write_reg(ADDR_COLOR_MODE, 32'(mode));
		write_reg(ADDR_CHANNEL_COUNT, 32'(count));
	endtask

	task automatic push_pixel(input logic [31:0] smp, input logic [31:0] back,
			input logic in_image);
		if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {back, smp};
		s_tuser <= in_image;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and let every outstanding pixel come back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pixels_in_flight != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		pmcab_pkg::color_mode_t mode_pick;
		int                     count_pick;
		logic [7:0]             fourth;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first setting runs on the reset values
		for (int c = 0; c < 8; c++) begin
			if (c != 0) begin
				program_config(dir_mode[c], dir_count[c]);
			end
			push_pixel(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
			push_pixel(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
			push_pixel(32'h7FC0_4080, 32'h80A5_5A3C, c[0] == 1'b0);
			wait_for_results();
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p < 6) begin
				mode_pick = fixed_mode[p];
				count_pick = fixed_count[p];
			end else begin
				mode_pick = pmcab_pkg::color_mode_t'($urandom_range(3));
				count_pick = $urandom_range(7);
			end
			program_config(mode_pick, count_pick);
			quiet = (p == QUIET_PHASE);
			for (int i = 0; i < PHASE_PIXELS; i++) begin
				// alpha / black channel leans toward the blend edges
				case ($urandom_range(9))
					0: fourth = 8'h00;
					1: fourth = 8'hFF;
					2: fourth = 8'h01;
					3: fourth = 8'hFE;
					default: fourth = 8'($urandom);
				endcase
				push_pixel({fourth, 24'($urandom)}, $urandom, $urandom_range(9) != 0);
			end
			wait_for_results();
			quiet = 1'b0;
		end

		if (fail_count == 0) begin
			$display("PASS pixel_mode_convert_and_alpha_blend");
		end else begin
			$display("FAIL pixel_mode_convert_and_alpha_blend");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAIL pixel_mode_convert_and_alpha_blend");
		$finish;
	end

endmodule
